// ===== hdl/mmfn_pkg.sv =====
package mmfn_pkg;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_NUM_FEATURES = 16;
    localparam int DEFAULT_SAMPLE_WIDTH = 16;

    // Fixed field widths.
    localparam int CMD_W      = 2;
    localparam int FEATURE_W  = 4;
    localparam int SCALED_W   = 16;
    localparam int STATUS_W   = 3;

    // Result tdata: scaled, then feature echo, padded to whole bytes.
    localparam int OUT_TDATA_W = ((SCALED_W + FEATURE_W + 7) / 8) * 8;

    // Command codes carried in s_axis_tuser.
    localparam logic [CMD_W-1:0] CMD_FIT       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRANSFORM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;

    // Result status codes carried in m_axis_tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_UNFITTED    = 3'd1,
        ST_ZERO_RANGE  = 3'd2,
        ST_CLAMP_LOW   = 3'd3,
        ST_CLAMP_HIGH  = 3'd4
    } status_t;

endpackage

// ===== hdl/min_max_feature_normaliser.sv =====
// Channel  | Dir | tdata (lowest bit first)                       | tuser
// s_axis   | in  | feature[3:0], value[SAMPLE_WIDTH+3:4], zero pad | command[1:0]
// m_axis   | out | scaled[15:0], feature_echo[19:16], zero pad     | status[2:0]
//
// A fit item is a table read, then a read-modify-write of the entry.
// A transform inside the fitted range takes a table read, evaluate, 16 steps
// of the shared restoring divider (one quotient bit per cycle), and the result hand-off.
// Transforms answered without division skip the divider; a clear item sweeps every entry.
// After reset the block sweeps the fitted flags of every entry before it takes an item.
// One item is worked on at a time; a finished result waits in the output register,
// and a later result waits in the block until that register is taken.
module min_max_feature_normaliser #(
    parameter int NUM_FEATURES = mmfn_pkg::DEFAULT_NUM_FEATURES,
    parameter int SAMPLE_WIDTH = mmfn_pkg::DEFAULT_SAMPLE_WIDTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // feature, value, zero pad
    input  logic [((mmfn_pkg::FEATURE_W + SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // command
    input  logic [mmfn_pkg::CMD_W-1:0]             s_axis_tuser,

    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // scaled, feature_echo, zero pad
    output logic [mmfn_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // status
    output logic [mmfn_pkg::STATUS_W-1:0]          m_axis_tuser
);
    import mmfn_pkg::*;

    localparam int SW        = SAMPLE_WIDTH;
    localparam int AW        = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int DIV_STEPS = SCALED_W;
    localparam int CW        = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic          fitted;
        logic [SW-1:0] hi;
        logic [SW-1:0] lo;
    } entry_t;

    // Statistics table: one entry per feature.
    entry_t mem [NUM_FEATURES];
    entry_t rd_entry_reg;

    state_t                 state_reg;
    logic [AW-1:0]          clr_cnt_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [FEATURE_W-1:0]   feat_reg;
    logic [SW-1:0]          x_reg;
    logic [SW-1:0]          rem_reg;
    logic [SW-1:0]          div_reg;
    logic [SCALED_W-1:0]    q_reg;
    logic [CW-1:0]          step_reg;
    status_t                res_status_reg;

    logic                   m_valid_reg;
    logic [SCALED_W-1:0]    m_scaled_reg;
    logic [FEATURE_W-1:0]   m_feat_reg;
    status_t                m_status_reg;

    logic                   s_accept;
    logic [FEATURE_W-1:0]   s_feature;
    logic [SW-1:0]          s_value;
    logic [AW-1:0]          rd_addr;
    logic                   in_range;
    logic                   hi_eq_lo;
    logic                   x_lt_lo;
    logic                   x_gt_hi;
    logic                   x_eq_hi;
    logic [SW-1:0]          x_minus_lo;
    logic [SW-1:0]          range_w;
    logic [SW:0]            shifted;
    logic [SW+1:0]          trial;
    logic                   ge;
    logic [SW-1:0]          rem_step;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    entry_t                 mem_wdata;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_feature     = s_axis_tdata[FEATURE_W-1:0];
    assign s_value       = s_axis_tdata[FEATURE_W+SW-1:FEATURE_W];
    assign rd_addr       = AW'(s_feature);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({m_feat_reg, m_scaled_reg});
    assign m_axis_tuser  = m_status_reg;

    // Entry checks for the latched item; all but the feature range check use the registered table data.
    assign in_range   = ({{(32 - FEATURE_W){1'b0}}, feat_reg} < 32'(NUM_FEATURES));
    assign hi_eq_lo   = (rd_entry_reg.hi == rd_entry_reg.lo);
    assign x_lt_lo    = ($signed(x_reg) < $signed(rd_entry_reg.lo));
    assign x_gt_hi    = ($signed(x_reg) > $signed(rd_entry_reg.hi));
    assign x_eq_hi    = (x_reg == rd_entry_reg.hi);
    assign x_minus_lo = x_reg - rd_entry_reg.lo;
    assign range_w    = rd_entry_reg.hi - rd_entry_reg.lo;

    // Shared restoring divider step. The remainder stays below the divisor,
    // so doubling it needs only one extra bit.
    assign shifted  = {rem_reg, 1'b0};
    assign trial    = {1'b0, shifted} - {2'b00, div_reg};
    assign ge       = !trial[SW+1];
    assign rem_step = ge ? trial[SW-1:0] : shifted[SW-1:0];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = AW'(feat_reg);
        mem_wdata = '{fitted: 1'b1, hi: x_reg, lo: x_reg};
        if (state_reg == S_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '{fitted: 1'b0, hi: '0, lo: '0};
        end else if (state_reg == S_EVAL && cmd_reg == CMD_FIT && in_range) begin
            mem_we = 1'b1;
            if (rd_entry_reg.fitted) begin
                mem_wdata.hi = x_gt_hi ? x_reg : rd_entry_reg.hi;
                mem_wdata.lo = x_lt_lo ? x_reg : rd_entry_reg.lo;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // The hand-off state decides the output valid itself.
            if (m_valid_reg && m_axis_tready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR: begin
                    if (clr_cnt_reg == AW'(NUM_FEATURES - 1)) begin
                        clr_cnt_reg <= '0;
                        state_reg   <= S_IDLE;
                    end else begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        cmd_reg   <= s_axis_tuser;
                        feat_reg  <= s_feature;
                        x_reg     <= s_value;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    case (cmd_reg)
                        CMD_CLEAR: begin
                            clr_cnt_reg <= '0;
                            state_reg   <= S_CLR;
                        end
                        CMD_TRANSFORM: begin
                            if (!in_range || !rd_entry_reg.fitted) begin
                                q_reg          <= '0;
                                res_status_reg <= ST_UNFITTED;
                                state_reg      <= S_DONE;
                            end else if (hi_eq_lo) begin
                                q_reg          <= '0;
                                res_status_reg <= ST_ZERO_RANGE;
                                state_reg      <= S_DONE;
                            end else if (x_lt_lo) begin
                                q_reg          <= '0;
                                res_status_reg <= ST_CLAMP_LOW;
                                state_reg      <= S_DONE;
                            end else if (x_gt_hi) begin
                                q_reg          <= '1;
                                res_status_reg <= ST_CLAMP_HIGH;
                                state_reg      <= S_DONE;
                            end else if (x_eq_hi) begin
                                // The exact quotient is one, which saturates.
                                q_reg          <= '1;
                                res_status_reg <= ST_OK;
                                state_reg      <= S_DONE;
                            end else begin
                                rem_reg        <= x_minus_lo;
                                div_reg        <= range_w;
                                q_reg          <= '0;
                                step_reg       <= '0;
                                res_status_reg <= ST_OK;
                                state_reg      <= S_DIV;
                            end
                        end
                        default: begin
                            // A fit item for a feature in range was written back this cycle; other codes are dropped.
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_DIV: begin
                    rem_reg  <= rem_step;
                    q_reg    <= {q_reg[SCALED_W-2:0], ge};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == CW'(DIV_STEPS - 1)) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg  <= 1'b1;
                        m_scaled_reg <= q_reg;
                        m_feat_reg   <= feat_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The divider never starts on an empty range and keeps its remainder below it.
    a_div_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> div_reg != '0 && rem_reg < div_reg)
        else $error("divider remainder out of bounds");

    // A new result only ever comes from the hand-off state.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside hand-off");

    // The table is never written while an item may be accepted.
    a_no_write_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !mem_we)
        else $error("table write while ready");

    // Zero-valued statuses carry a zero scaled value, a high clamp carries full scale.
    a_status_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == ST_UNFITTED || m_status_reg == ST_ZERO_RANGE
            || m_status_reg == ST_CLAMP_LOW) |-> m_scaled_reg == '0)
        else $error("status and scaled value disagree");

    a_clamp_high_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == ST_CLAMP_HIGH |-> m_scaled_reg == '1)
        else $error("high clamp without full scale");

endmodule
